// ----- hw/rtl/mte_pkg.sv -----
package mte_pkg;

  // fixed field widths
  localparam int SAMPLE_BITS = 24;
  localparam int CMD_W       = 2;
  localparam int STATE_W     = 3;
  localparam int OUT_CNT_W   = 32;
  localparam int PROB_W      = 17;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int NSTATES_W   = 4;
  localparam int FRAC_BITS   = 8;

  // defaults for the top level parameters
  localparam int MAX_STATES_DEF = 8;
  localparam int COUNT_BITS_DEF = 32;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_STATES = 2'd3;

  // configuration reset values
  localparam logic [SAMPLE_BITS-1:0] RANGE_MIN_RST  = 24'd0;
  localparam logic [SAMPLE_BITS-1:0] RANGE_MAX_RST  = 24'hFFFFFF;
  localparam logic [CFG_W-1:0]       BIN_WIDTH_RST  = 32'h2000_0000;
  localparam logic [NSTATES_W-1:0]   NUM_STATES_RST = 4'd8;

  // probability of one, 16 fractional bits
  localparam logic [PROB_W-1:0] PROB_MAX = 17'h10000;

  // one result word
  typedef struct packed {
    logic [STATE_W-1:0]   state_index;
    logic                 out_of_range;
    logic [OUT_CNT_W-1:0] entry_count;
    logic [OUT_CNT_W-1:0] row_total;
    logic [PROB_W-1:0]    probability;
  } res_t;

endpackage

// ----- hw/rtl/mte_if.sv -----
interface mte_in_if;
  logic                           valid;
  logic                           ready;
  logic [mte_pkg::CMD_W-1:0]       command;
  logic [mte_pkg::SAMPLE_BITS-1:0] sample;
  logic [mte_pkg::STATE_W-1:0]     from_state;
  logic [mte_pkg::STATE_W-1:0]     to_state;

  modport source (output valid, command, sample, from_state, to_state, input ready);
  modport sink (input valid, command, sample, from_state, to_state, output ready);
endinterface

interface mte_out_if;
  logic                          valid;
  logic                          ready;
  logic [mte_pkg::STATE_W-1:0]   state_index;
  logic                          out_of_range;
  logic [mte_pkg::OUT_CNT_W-1:0] entry_count;
  logic [mte_pkg::OUT_CNT_W-1:0] row_total;
  logic [mte_pkg::PROB_W-1:0]    probability;

  modport source (output valid, state_index, out_of_range, entry_count, row_total,
                  probability, input ready);
  modport sink (input valid, state_index, out_of_range, entry_count, row_total,
                probability, output ready);
endinterface

// ----- hw/rtl/markov_transition_estimator.sv -----
// Markov transition matrix estimator.
// in_ch carries one command word: add a sample, read one matrix entry, or clear
// the counts. out_ch returns exactly one result word for every command word.
// cfg_we/cfg_index/cfg_data write range_min, range_max, bin_width, num_states;
// write them only while the block is idle.
// A sample is binned in the accept cycle by comparing against thresholds that
// are precomputed when bin_width is written; its counter and row sum are then
// updated, if a prior sample exists, by a read-modify-write of the counter
// memories; no new command word is taken until that write-back is done.
// A read fetches the entry and its row total; if that total is nonzero, a
// shift-subtract divider forms the probability (one quotient bit a cycle).
// A clear, and reset itself, sweeps the counter memories one entry a cycle,
// during which no command word is taken; configuration writes are still
// accepted.
// Results go through a holding stage and an output register, so one command
// word may be taken while a finished result waits. When out_ch stalls, both
// fill and in_ch.ready drops.
module markov_transition_estimator #(
  parameter int MAX_STATES = mte_pkg::MAX_STATES_DEF,
  parameter int COUNT_BITS = mte_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mte_in_if.sink                          in_ch,
  mte_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [mte_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mte_pkg::CFG_W-1:0]       cfg_data
);

  localparam int SB        = mte_pkg::SAMPLE_BITS;
  localparam int IDXW      = $clog2(MAX_STATES);
  localparam int AW        = 2 * IDXW;
  localparam int DEPTH     = 1 << AW;
  localparam int ROWS      = 1 << IDXW;
  localparam int THR_W     = mte_pkg::CFG_W + IDXW;
  localparam int DIFF_W    = SB + mte_pkg::FRAC_BITS;
  localparam int CMP_W     = (DIFF_W > THR_W) ? DIFF_W : THR_W;
  localparam int NS_W      = (IDXW + 1 > mte_pkg::NSTATES_W) ? IDXW + 1 : mte_pkg::NSTATES_W;
  localparam int DIV_STEPS = mte_pkg::PROB_W + 1;
  localparam int QW        = DIV_STEPS;
  localparam int DW        = COUNT_BITS + DIV_STEPS - 1;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_UPD  = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_CLR  = 3'd4;

  // saturating increment
  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (&v) ? v : v + COUNT_BITS'(1);
  endfunction

  // configuration
  logic [SB-1:0]                   rmin_r;
  logic [SB-1:0]                   rmax_r;
  logic [mte_pkg::NSTATES_W-1:0]   nstates_r;
  logic [THR_W-1:0]                thr_r [1:MAX_STATES-1];
  logic [mte_pkg::CFG_W-1:0]       bw_eff;

  // control
  logic [2:0]            st_r, st_nxt;
  logic [AW-1:0]         ptr_r, ptr_nxt;
  logic [IDXW-1:0]       prev_r, prev_nxt;
  logic                  prev_vld_r, prev_vld_nxt;
  logic                  pend_vld_r, pend_vld_nxt;
  logic                  out_vld_r, out_vld_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;

  // payload
  logic [AW-1:0]            upd_addr_r, upd_addr_nxt;
  mte_pkg::res_t            pend_r, pend_nxt;
  mte_pkg::res_t            out_r, out_nxt;
  logic [DW-1:0]            rem_r, rem_nxt;
  logic [DW-1:0]            dvs_r, dvs_nxt;
  logic [QW-1:0]            q_r, q_nxt;
  logic [COUNT_BITS-1:0]    ent_r, ent_nxt;
  logic [COUNT_BITS-1:0]    tot_r, tot_nxt;

  // memories
  logic [COUNT_BITS-1:0] cnt_mem [DEPTH];
  logic [COUNT_BITS-1:0] row_mem [ROWS];
  logic [COUNT_BITS-1:0] cnt_rd_r, row_rd_r;
  logic                  cnt_we, row_we, rd_en;
  logic [AW-1:0]         cnt_wa, cnt_ra;
  logic [IDXW-1:0]       row_wa, row_ra;
  logic [COUNT_BITS-1:0] cnt_wd, row_wd;

  // handshake and datapath helpers
  logic                  in_rdy, acc, pend_mv;
  logic                  below, above, flag;
  logic [SB-1:0]         sdiff;
  logic [CMP_W-1:0]      dcmp;
  logic [NS_W-1:0]       ns;
  logic [IDXW-1:0]       n_m1, bin, cur;
  logic                  rd_ok;
  logic [IDXW-1:0]       rd_row, rd_col;
  logic                  ge;
  logic [QW-1:0]         q_step;
  logic [mte_pkg::PROB_W-1:0] prob;

  // configuration registers and bin thresholds
  assign bw_eff = (cfg_data == '0) ? mte_pkg::CFG_W'(1) : cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rmin_r    <= mte_pkg::RANGE_MIN_RST;
      rmax_r    <= mte_pkg::RANGE_MAX_RST;
      nstates_r <= mte_pkg::NUM_STATES_RST;
      for (int i = 1; i < MAX_STATES; i++) begin
        thr_r[i] <= THR_W'(i) * THR_W'(mte_pkg::BIN_WIDTH_RST);
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        mte_pkg::CFG_RANGE_MIN:  rmin_r    <= cfg_data[SB-1:0];
        mte_pkg::CFG_RANGE_MAX:  rmax_r    <= cfg_data[SB-1:0];
        mte_pkg::CFG_BIN_WIDTH: begin
          for (int i = 1; i < MAX_STATES; i++) begin
            thr_r[i] <= THR_W'(i) * THR_W'(bw_eff);
          end
        end
        mte_pkg::CFG_NUM_STATES: nstates_r <= cfg_data[mte_pkg::NSTATES_W-1:0];
        default: ;
      endcase
    end
  end

  // bin search by direct compare against the thresholds
  always_comb begin
    ns = NS_W'(nstates_r);
    if (ns < NS_W'(2)) begin
      ns = NS_W'(2);
    end else if (ns > NS_W'(MAX_STATES)) begin
      ns = NS_W'(MAX_STATES);
    end
    n_m1  = IDXW'(ns - NS_W'(1));
    below = in_ch.sample < rmin_r;
    above = in_ch.sample > rmax_r;
    sdiff = in_ch.sample - rmin_r;
    dcmp  = CMP_W'({sdiff, {mte_pkg::FRAC_BITS{1'b0}}});
    bin   = '0;
    for (int i = 1; i < MAX_STATES; i++) begin
      if ((IDXW'(i) <= n_m1) && (dcmp >= CMP_W'(thr_r[i]))) begin
        bin = bin + IDXW'(1);
      end
    end
    flag = below | above;
    cur  = below ? '0 : (above ? n_m1 : bin);
  end

  // read command addressing
  assign rd_ok  = (int'(in_ch.from_state) < MAX_STATES) && (int'(in_ch.to_state) < MAX_STATES);
  assign rd_row = IDXW'(in_ch.from_state);
  assign rd_col = IDXW'(in_ch.to_state);

  // handshake
  assign in_rdy      = (st_r == ST_IDLE) && !pend_vld_r;
  assign in_ch.ready = in_rdy;
  assign acc         = in_ch.valid && in_rdy;
  assign pend_mv     = pend_vld_r && (!out_vld_r || out_ch.ready);

  // divider step
  assign ge     = rem_r >= dvs_r;
  assign q_step = {q_r[QW-2:0], ge};
  assign prob   = (q_step[QW-1] || (q_step[QW-2:0] > mte_pkg::PROB_MAX)) ?
                  mte_pkg::PROB_MAX : q_step[QW-2:0];

  // memory ports
  always_comb begin
    rd_en  = acc;
    cnt_ra = (in_ch.command == mte_pkg::CMD_ADD) ? {prev_r, cur} : {rd_row, rd_col};
    row_ra = (in_ch.command == mte_pkg::CMD_ADD) ? prev_r : rd_row;
    cnt_we = 1'b0;
    row_we = 1'b0;
    cnt_wa = upd_addr_r;
    row_wa = upd_addr_r[AW-1:IDXW];
    cnt_wd = sat_inc(cnt_rd_r);
    row_wd = sat_inc(row_rd_r);
    if (st_r == ST_CLR) begin
      cnt_we = 1'b1;
      row_we = 1'b1;
      cnt_wa = ptr_r;
      row_wa = ptr_r[IDXW-1:0];
      cnt_wd = '0;
      row_wd = '0;
    end else if (st_r == ST_UPD) begin
      cnt_we = 1'b1;
      row_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (rd_en) cnt_rd_r <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk) begin
    if (row_we) row_mem[row_wa] <= row_wd;
    if (rd_en) row_rd_r <= row_mem[row_ra];
  end

  // sequencer
  always_comb begin
    st_nxt       = st_r;
    ptr_nxt      = ptr_r;
    prev_nxt     = prev_r;
    prev_vld_nxt = prev_vld_r;
    step_nxt     = step_r;
    upd_addr_nxt = upd_addr_r;
    rem_nxt      = rem_r;
    dvs_nxt      = dvs_r;
    q_nxt        = q_r;
    ent_nxt      = ent_r;
    tot_nxt      = tot_r;
    pend_nxt     = pend_r;
    pend_vld_nxt = pend_mv ? 1'b0 : pend_vld_r;

    unique case (st_r)
      ST_IDLE: begin
        if (acc) begin
          pend_nxt     = '0;
          pend_vld_nxt = 1'b1;
          unique case (in_ch.command)
            mte_pkg::CMD_ADD: begin
              pend_nxt.state_index  = mte_pkg::STATE_W'(cur);
              pend_nxt.out_of_range = flag;
              prev_nxt              = cur;
              prev_vld_nxt          = 1'b1;
              upd_addr_nxt          = {prev_r, cur};
              if (prev_vld_r) st_nxt = ST_UPD;
            end
            mte_pkg::CMD_READ: begin
              if (rd_ok) begin
                pend_vld_nxt = 1'b0;
                st_nxt       = ST_RD;
              end
            end
            mte_pkg::CMD_CLEAR: begin
              prev_nxt     = '0;
              prev_vld_nxt = 1'b0;
              ptr_nxt      = '0;
              st_nxt       = ST_CLR;
            end
            default: ;
          endcase
        end
      end
      ST_UPD: begin
        st_nxt = ST_IDLE;
      end
      ST_RD: begin
        ent_nxt = cnt_rd_r;
        tot_nxt = row_rd_r;
        if (row_rd_r == '0) begin
          pend_nxt             = '0;
          pend_nxt.entry_count = mte_pkg::OUT_CNT_W'(cnt_rd_r);
          pend_vld_nxt         = 1'b1;
          st_nxt               = ST_IDLE;
        end else begin
          rem_nxt  = {1'b0, cnt_rd_r, 16'b0} + DW'(row_rd_r >> 1);
          dvs_nxt  = {row_rd_r, {(DIV_STEPS - 1){1'b0}}};
          q_nxt    = '0;
          step_nxt = STEP_W'(DIV_STEPS - 1);
          st_nxt   = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt  = ge ? rem_r - dvs_r : rem_r;
        dvs_nxt  = dvs_r >> 1;
        q_nxt    = q_step;
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          pend_nxt             = '0;
          pend_nxt.entry_count = mte_pkg::OUT_CNT_W'(ent_r);
          pend_nxt.row_total   = mte_pkg::OUT_CNT_W'(tot_r);
          pend_nxt.probability = prob;
          pend_vld_nxt         = 1'b1;
          st_nxt               = ST_IDLE;
        end
      end
      ST_CLR: begin
        ptr_nxt = ptr_r + AW'(1);
        if (&ptr_r) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_nxt     = pend_mv ? pend_r : out_r;
    out_vld_nxt = pend_mv ? 1'b1 : (out_ch.ready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_CLR;
      ptr_r      <= '0;
      prev_r     <= '0;
      prev_vld_r <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      step_r     <= '0;
    end else begin
      st_r       <= st_nxt;
      ptr_r      <= ptr_nxt;
      prev_r     <= prev_nxt;
      prev_vld_r <= prev_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      step_r     <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    upd_addr_r <= upd_addr_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    rem_r      <= rem_nxt;
    dvs_r      <= dvs_nxt;
    q_r        <= q_nxt;
    ent_r      <= ent_nxt;
    tot_r      <= tot_nxt;
  end

  // result port
  assign out_ch.valid        = out_vld_r;
  assign out_ch.state_index  = out_r.state_index;
  assign out_ch.out_of_range = out_r.out_of_range;
  assign out_ch.entry_count  = out_r.entry_count;
  assign out_ch.row_total    = out_r.row_total;
  assign out_ch.probability  = out_r.probability;

  // a sample after a prior one always goes through the write-back cycle
  a_upd_after_add: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.command == mte_pkg::CMD_ADD && prev_vld_r) |=> (st_r == ST_UPD))
    else $error("sample update skipped write-back");

  // a clear starts the sweep at entry zero and forgets the prior sample
  a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.command == mte_pkg::CMD_CLEAR) |=>
    (st_r == ST_CLR && ptr_r == '0 && !prev_vld_r))
    else $error("clear did not start sweep");

  // a held result is never overwritten before it moves on
  a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_vld_r && !pend_mv) |=> (pend_vld_r && $stable(pend_r)))
    else $error("pending result lost");

  // the divider never runs past its last quotient bit
  a_div_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DIV) |-> (step_r <= STEP_W'(DIV_STEPS - 1)))
    else $error("divider step count out of range");

  // probability never exceeds one
  a_prob_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.probability <= mte_pkg::PROB_MAX))
    else $error("probability above one");

endmodule
